@@ sv/ptat_pkg.sv @@
// Shared types and constants for the page table address translator.
package ptat_pkg;

  localparam int ADDR_W     = 32;
  localparam int SHIFT_W    = 5;
  localparam int CFG_CNT_W  = 9;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int EPAGE_W    = 8;
  localparam int EFRAME_W   = 8;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_REVERSE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_RANGE      = 3'd1,
    ST_UNASSIGNED = 3'd2,
    ST_NOT_MAPPED = 3'd3,
    ST_BAD        = 3'd4
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT = 2'd2;

  localparam logic [SHIFT_W-1:0]   RST_PAGE_SHIFT  = 5'd12;
  localparam logic [CFG_CNT_W-1:0] RST_PAGE_COUNT  = 9'd256;
  localparam logic [CFG_CNT_W-1:0] RST_FRAME_LIMIT = 9'd256;

  typedef struct packed {
    logic [OP_W-1:0]     opcode;
    logic [ADDR_W-1:0]   address;
    logic [EPAGE_W-1:0]  entry_page;
    logic [EFRAME_W-1:0] entry_frame;
    logic                entry_assigned;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   result_address;
    logic [STATUS_W-1:0] status;
  } out_t;

  // Control part of a token walking down the cell row
  typedef struct packed {
    logic              vld;
    logic [OP_W-1:0]   op;
    logic              done;
    status_t           status;
    logic              assigned;
    logic [ADDR_W-1:0] off;
  } tok_ctl_t;

endpackage

@@ sv/page_table_address_translator_core.sv @@
// Top level of the page table address translator.
// A word passes through the decode stage, the page cells and the exit stage in order.
// Throughput: one word per cycle when not stalled; tokens step one page cell a cycle.
// A stalled result freezes the whole row, so the input stalls with it.
// Reset (synchronous, active low) marks every entry unassigned at once and restores
// page shift 12, page count 256 and frame count 256.
module page_table_address_translator_core #(
  parameter int PAGES      = 256,
  parameter int FRAME_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ptat_pkg::in_t                   in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ptat_pkg::out_t                  out_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ptat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptat_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ptat_pkg::*;

  localparam int PAGE_W = $clog2(PAGES);
  localparam int KW0    = (PAGE_W > FRAME_BITS) ? PAGE_W : FRAME_BITS;
  localparam int KEY_W  = (KW0 > CFG_CNT_W) ? KW0 : CFG_CNT_W;
  localparam int CNT_W  = (PAGE_W + 1 > CFG_CNT_W) ? PAGE_W + 1 : CFG_CNT_W;

  logic [SHIFT_W-1:0]   page_shift_r;
  logic [CFG_CNT_W-1:0] page_count_r;
  logic [CFG_CNT_W-1:0] frame_limit_r;
  logic [CNT_W-1:0]     npages;
  logic                 adv;

  tok_ctl_t              ctl_c [PAGES+1];
  logic [KEY_W-1:0]      key_c [PAGES+1];
  logic [FRAME_BITS-1:0] frm_c [PAGES+1];

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_shift_r  <= RST_PAGE_SHIFT;
      page_count_r  <= RST_PAGE_COUNT;
      frame_limit_r <= RST_FRAME_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PAGE_SHIFT:  page_shift_r  <= SHIFT_W'(cfg_data);
        CFG_PAGE_COUNT:  page_count_r  <= CFG_CNT_W'(cfg_data);
        CFG_FRAME_LIMIT: frame_limit_r <= CFG_CNT_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Clamp the page count to the table size
  assign npages = (CNT_W'(page_count_r) > CNT_W'(PAGES)) ? CNT_W'(PAGES)
                                                          : CNT_W'(page_count_r);

  // Advance the row whenever the result register is free or being taken
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  ptat_decode #(
    .FRAME_BITS (FRAME_BITS),
    .KEY_W      (KEY_W),
    .CNT_W      (CNT_W)
  ) u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (in_valid),
    .in_word     (in_word),
    .page_shift  (page_shift_r),
    .npages      (npages),
    .frame_limit (frame_limit_r),
    .ctl_r       (ctl_c[0]),
    .key_r       (key_c[0]),
    .frm_r       (frm_c[0])
  );

  for (genvar i = 0; i < PAGES; i++) begin : g_cell
    ptat_cell #(
      .IDX        (i),
      .FRAME_BITS (FRAME_BITS),
      .KEY_W      (KEY_W),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .npages (npages),
      .ctl_in (ctl_c[i]),
      .key_in (key_c[i]),
      .frm_in (frm_c[i]),
      .ctl_r  (ctl_c[i+1]),
      .key_r  (key_c[i+1]),
      .frm_r  (frm_c[i+1])
    );
  end

  ptat_emit #(
    .KEY_W (KEY_W)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .page_shift (page_shift_r),
    .ctl_in     (ctl_c[PAGES]),
    .key_in     (key_c[PAGES]),
    .out_valid  (out_valid),
    .out_word   (out_word)
  );

  a_row_frozen : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(ctl_c[PAGES].vld) && out_valid)
    else $error("row moved while the result was stalled");

  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ctl_c[0].vld)
    else $error("accepted word did not enter the row");

  a_idle_row_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid && adv |=> !ctl_c[0].vld)
    else $error("token appeared without an accepted word");

endmodule

@@ sv/ptat_decode.sv @@
// Entry stage: split the address, range check, and build the token.
module ptat_decode #(
  parameter int FRAME_BITS = 8,
  parameter int KEY_W      = 9,
  parameter int CNT_W      = 9
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_valid,
  input  ptat_pkg::in_t             in_word,
  input  logic [ptat_pkg::SHIFT_W-1:0]   page_shift,
  input  logic [CNT_W-1:0]               npages,
  input  logic [ptat_pkg::CFG_CNT_W-1:0] frame_limit,
  output ptat_pkg::tok_ctl_t        ctl_r,
  output logic [KEY_W-1:0]          key_r,
  output logic [FRAME_BITS-1:0]     frm_r
);
  import ptat_pkg::*;

  logic [ADDR_W-1:0]     hi;
  logic [ADDR_W-1:0]     off_mask;
  logic                  frame_fits;
  logic                  write_ok;
  tok_ctl_t              ctl_nxt;
  logic [KEY_W-1:0]      key_nxt;
  logic [FRAME_BITS-1:0] frm_nxt;

  // Split address into page or frame number and offset
  assign hi       = in_word.address >> page_shift;
  assign off_mask = ~({ADDR_W{1'b1}} << page_shift);

  // Check a write against the page and frame limits
  assign frame_fits = (in_word.entry_frame >> FRAME_BITS) == '0;
  assign write_ok   = (CNT_W'(in_word.entry_page) < npages) &&
                      (!in_word.entry_assigned ||
                       ((CFG_CNT_W'(in_word.entry_frame) < frame_limit) && frame_fits));

  always_comb begin
    ctl_nxt.vld      = in_valid;
    ctl_nxt.op       = in_word.opcode;
    ctl_nxt.done     = 1'b1;
    ctl_nxt.status   = ST_BAD;
    ctl_nxt.assigned = in_word.entry_assigned;
    ctl_nxt.off      = in_word.address & off_mask;
    key_nxt          = KEY_W'(hi);
    frm_nxt          = FRAME_BITS'(in_word.entry_frame);
    unique case (in_word.opcode)
      OP_WRITE: begin
        key_nxt = KEY_W'(in_word.entry_page);
        if (write_ok) begin
          ctl_nxt.done   = 1'b0;
          ctl_nxt.status = ST_OK;
        end
      end
      OP_LOOKUP: begin
        if (hi >= ADDR_W'(npages)) begin
          ctl_nxt.status = ST_RANGE;
        end else begin
          ctl_nxt.done   = 1'b0;
          ctl_nxt.status = ST_UNASSIGNED;
        end
      end
      OP_REVERSE: begin
        if (hi >= ADDR_W'(frame_limit)) begin
          ctl_nxt.status = ST_RANGE;
        end else begin
          ctl_nxt.done   = 1'b0;
          ctl_nxt.status = ST_NOT_MAPPED;
        end
      end
      default: begin
        ctl_nxt.done   = 1'b1;
        ctl_nxt.status = ST_BAD;
      end
    endcase
  end

  // Load the token when the row advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
      key_r <= key_nxt;
      frm_r <= frm_nxt;
    end
  end

endmodule

@@ sv/ptat_cell.sv @@
// One page table cell: holds one entry and serves the token passing by.
module ptat_cell #(
  parameter int IDX        = 0,
  parameter int FRAME_BITS = 8,
  parameter int KEY_W      = 9,
  parameter int CNT_W      = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic [CNT_W-1:0]      npages,
  input  ptat_pkg::tok_ctl_t    ctl_in,
  input  logic [KEY_W-1:0]      key_in,
  input  logic [FRAME_BITS-1:0] frm_in,
  output ptat_pkg::tok_ctl_t    ctl_r,
  output logic [KEY_W-1:0]      key_r,
  output logic [FRAME_BITS-1:0] frm_r
);
  import ptat_pkg::*;

  logic                  ent_vld_r;
  logic                  ent_vld_nxt;
  logic [FRAME_BITS-1:0] ent_frm_r;
  logic [FRAME_BITS-1:0] ent_frm_nxt;
  tok_ctl_t              ctl_nxt;
  logic [KEY_W-1:0]      key_nxt;
  logic                  live;
  logic                  idx_hit;
  logic                  wr_hit;
  logic                  frm_hit;

  assign live    = ctl_in.vld && !ctl_in.done;
  assign idx_hit = key_in == KEY_W'(IDX);
  assign wr_hit  = live && (ctl_in.op == OP_WRITE) && idx_hit;
  assign frm_hit = ent_vld_r && (KEY_W'(ent_frm_r) == key_in) && (CNT_W'(IDX) < npages);

  // Serve the token against this entry
  always_comb begin
    ctl_nxt     = ctl_in;
    key_nxt     = key_in;
    ent_vld_nxt = ent_vld_r;
    ent_frm_nxt = ent_frm_r;
    if (live) begin
      unique case (ctl_in.op)
        OP_WRITE: begin
          if (idx_hit) begin
            ent_vld_nxt  = ctl_in.assigned;
            ent_frm_nxt  = ctl_in.assigned ? frm_in : '0;
            ctl_nxt.done = 1'b1;
          end
        end
        OP_LOOKUP: begin
          if (idx_hit) begin
            ctl_nxt.done = 1'b1;
            if (ent_vld_r) begin
              ctl_nxt.status = ST_OK;
              key_nxt        = KEY_W'(ent_frm_r);
            end else begin
              ctl_nxt.status = ST_UNASSIGNED;
            end
          end
        end
        OP_REVERSE: begin
          if (frm_hit) begin
            ctl_nxt.done   = 1'b1;
            ctl_nxt.status = ST_OK;
            key_nxt        = KEY_W'(IDX);
          end
        end
        default: begin
          ctl_nxt.done = 1'b1;
        end
      endcase
    end
  end

  // Hand the token to the next cell and update the entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
      ent_vld_r <= 1'b0;
    end else if (adv) begin
      ctl_r     <= ctl_nxt;
      key_r     <= key_nxt;
      frm_r     <= frm_in;
      ent_vld_r <= ent_vld_nxt;
      ent_frm_r <= ent_frm_nxt;
    end
  end

  a_done_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    adv && ctl_in.vld && ctl_in.done |=> ctl_r.done)
    else $error("finished token reopened in cell");

  a_entry_write_only : assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && wr_hit) |=> $stable(ent_vld_r))
    else $error("entry changed without a matching write");

  a_lookup_served : assert property (@(posedge clk) disable iff (!rst_n)
    adv && live && (ctl_in.op == OP_LOOKUP) && idx_hit |=> ctl_r.done && ctl_r.vld)
    else $error("lookup passed its page cell unserved");

endmodule

@@ sv/ptat_emit.sv @@
// Exit stage: form the translated address and hold the result word.
module ptat_emit #(
  parameter int KEY_W = 9
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic [ptat_pkg::SHIFT_W-1:0] page_shift,
  input  ptat_pkg::tok_ctl_t           ctl_in,
  input  logic [KEY_W-1:0]             key_in,
  output logic                         out_valid,
  output ptat_pkg::out_t               out_word
);
  import ptat_pkg::*;

  logic              out_valid_r;
  out_t              out_word_r;
  out_t              out_word_nxt;
  logic              give_addr;

  // Only successful translations carry an address
  assign give_addr = (ctl_in.status == ST_OK) && (ctl_in.op != OP_WRITE);

  always_comb begin
    out_word_nxt.status         = ctl_in.status;
    out_word_nxt.result_address = give_addr ?
        ((ADDR_W'(key_in) << page_shift) + ctl_in.off) : '0;
  end

  // Hold the word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_in.vld;
      out_word_r  <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ sim/tb_page_table_address_translator_core.sv @@
// Self-checking regression bench for the page table address translator core.
`timescale 1ns / 1ps

module tb_page_table_address_translator_core;
  import ptat_pkg::*;

  localparam int PAGES       = 256;
  localparam int FRAME_BITS  = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 700;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t in_word;
  logic out_valid;
  logic out_stall;
  out_t out_word;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the translator: page table and registers
  logic [FRAME_BITS:0] page_map [PAGES];
  logic [SHIFT_W-1:0] shadow_shift;
  logic [CFG_CNT_W-1:0] shadow_pages;
  logic [CFG_CNT_W-1:0] shadow_frames;

  out_t pending_results [$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_asks;
  int words_sent;
  int results_checked;
  int reg_writes;
  int mismatch_count;
  int cycle_count;

  page_table_address_translator_core #(
    .PAGES(PAGES),
    .FRAME_BITS(FRAME_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Number of pages actually in use
  function automatic int unsigned live_pages();
    return (shadow_pages > PAGES) ? PAGES : shadow_pages;
  endfunction

  // Translate one word against the shadow table, applying any table write
  function automatic out_t translate_word(in_t w);
    out_t r;
    logic [63:0] hi;
    logic [63:0] off;
    logic [63:0] offmask;
    logic [63:0] res;
    int unsigned npages;
    bit found;
    status_t st;
    npages = live_pages();
    offmask = (64'd1 << shadow_shift) - 64'd1;
    hi = {32'd0, w.address} >> shadow_shift;
    off = {32'd0, w.address} & offmask;
    res = 64'd0;
    st = ST_BAD;
    found = 1'b0;
    case (w.opcode)
      OP_WRITE: begin
        if (w.entry_page < npages) begin
          if (!w.entry_assigned) begin
            page_map[w.entry_page] = '0;
            st = ST_OK;
          end else if (w.entry_frame < shadow_frames) begin
            page_map[w.entry_page] = {1'b1, w.entry_frame};
            st = ST_OK;
          end
        end
      end
      OP_LOOKUP: begin
        if (hi >= npages) begin
          st = ST_RANGE;
        end else if (!page_map[hi[7:0]][FRAME_BITS]) begin
          st = ST_UNASSIGNED;
        end else begin
          res = ({56'd0, page_map[hi[7:0]][FRAME_BITS-1:0]} << shadow_shift) + off;
          st = ST_OK;
        end
      end
      OP_REVERSE: begin
        if (hi >= shadow_frames) begin
          st = ST_RANGE;
        end else begin
          // Search upward; the lowest matching page wins
          st = ST_NOT_MAPPED;
          for (int i = 0; i < npages && !found; i++) begin
            if (page_map[i][FRAME_BITS] && page_map[i][FRAME_BITS-1:0] == hi) begin
              res = (64'(i) << shadow_shift) + off;
              st = ST_OK;
              found = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    r.result_address = res[ADDR_W-1:0];
    r.status = st;
    return r;
  endfunction

  function automatic in_t make_word(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                    logic [7:0] page, logic [7:0] frame, logic asg);
    in_t w;
    w.opcode = op;
    w.address = addr;
    w.entry_page = page;
    w.entry_frame = frame;
    w.entry_assigned = asg;
    return w;
  endfunction

  // Build an address with the given page or frame number and a random offset
  function automatic logic [ADDR_W-1:0] place_number(int unsigned num, logic [ADDR_W-1:0] raw);
    logic [63:0] mask;
    logic [63:0] v;
    mask = (64'd1 << shadow_shift) - 64'd1;
    v = (64'(num) << shadow_shift) | ({32'd0, raw} & mask);
    return v[ADDR_W-1:0];
  endfunction

  // Mostly well-formed traffic with random content, some noise
  function automatic in_t random_word();
    in_t w;
    int unsigned kind;
    int unsigned npages;
    int unsigned nframes;
    int unsigned pick;
    npages = live_pages();
    nframes = (shadow_frames > PAGES) ? PAGES : shadow_frames;
    w = make_word(OP_W'($urandom_range(0, 3)), $urandom(), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      return w;
    end else if (kind < 45) begin
      w.opcode = OP_WRITE;
      if (npages > 0 && $urandom_range(0, 9) != 0)
        w.entry_page = 8'($urandom_range(0, npages - 1));
      if (nframes > 0 && $urandom_range(0, 9) != 0)
        w.entry_frame = 8'($urandom_range(0, nframes - 1));
      w.entry_assigned = ($urandom_range(0, 7) != 0);
    end else if (kind < 75) begin
      w.opcode = OP_LOOKUP;
      pick = (npages > 0) ? $urandom_range(0, npages - 1) : 0;
      w.address = place_number(pick, $urandom());
    end else begin
      w.opcode = OP_REVERSE;
      pick = (npages > 0) ? $urandom_range(0, npages - 1) : 0;
      if ($urandom_range(0, 5) == 0)
        pick = $urandom_range(0, shadow_frames);
      else if (page_map[pick][FRAME_BITS])
        pick = 32'(page_map[pick][FRAME_BITS-1:0]);
      else
        pick = (nframes > 0) ? $urandom_range(0, nframes - 1) : 0;
      w.address = place_number(pick, $urandom());
    end
    return w;
  endfunction

  // Offer one word; leave valid high after acceptance (lowered when the next call idles, or by wait_idle)
  task automatic send_word(in_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(translate_word(w));
    words_sent++;
    @(negedge clk);
  endtask

  // Drop the input and wait for every pending result
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_PAGE_SHIFT:  shadow_shift = data[SHIFT_W-1:0];
      CFG_PAGE_COUNT:  shadow_pages = data;
      CFG_FRAME_LIMIT: shadow_frames = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_regs(logic [SHIFT_W-1:0] shift, logic [CFG_CNT_W-1:0] pages,
                          logic [CFG_CNT_W-1:0] frames);
    write_reg(CFG_PAGE_SHIFT, {4'($urandom_range(0, 15)), shift});
    write_reg(CFG_PAGE_COUNT, pages);
    write_reg(CFG_FRAME_LIMIT, frames);
  endtask

  task automatic report_mismatch(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
    $display("MISMATCH %s: got 0x%08h, expected 0x%08h (result %0d)",
             what, got, want, results_checked);
    mismatch_count++;
  endtask

  // Check each accepted result word against the oldest prediction
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no word pending", out_word.result_address, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_word.result_address !== want.result_address)
          report_mismatch("result_address", out_word.result_address, want.result_address);
        if (out_word.status !== want.status)
          report_mismatch("status", {29'd0, out_word.status}, {29'd0, want.status});
      end
      results_checked++;
    end
  end

  // Receiver: random stalls, plus long holds on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("page_table_address_translator_core regression: fail");
    $finish;
  end

  // Fresh table: empty lookups and searches, address beyond the page count
  task automatic test_reset_state();
    send_word(make_word(OP_LOOKUP, 32'h0000_0000, 8'd0, 8'd0, 1'b0));
    send_word(make_word(OP_REVERSE, 32'h0000_0ABC, 8'd0, 8'd0, 1'b0));
    send_word(make_word(OP_LOOKUP, 32'hFFFF_FFFF, 8'd0, 8'd0, 1'b0));
  endtask

  // Table loads, a shared frame, unassign and the unused opcode
  task automatic test_write_rules();
    send_word(make_word(OP_WRITE, 32'h0, 8'd0, 8'd255, 1'b1));
    send_word(make_word(OP_WRITE, 32'h0, 8'd255, 8'd0, 1'b1));
    send_word(make_word(OP_WRITE, 32'h0, 8'd7, 8'd255, 1'b1));
    send_word(make_word(OP_LOOKUP, 32'h0000_0FFF, 8'd0, 8'd0, 1'b0));
    send_word(make_word(OP_REVERSE, 32'h000F_F123, 8'd0, 8'd0, 1'b0));
    send_word(make_word(OP_LOOKUP, 32'h000F_F000, 8'd0, 8'd0, 1'b0));
    send_word(make_word(OP_WRITE, 32'h0, 8'd3, 8'd0, 1'b0));
    send_word(make_word(OP_UNUSED, 32'hFFFF_FFFF, 8'd255, 8'd255, 1'b1));
  endtask

  // Shrunk counts, zero pages, oversized counts, extreme shifts
  task automatic test_config_extremes();
    set_regs(5'd12, 9'd4, 9'd10);
    send_word(make_word(OP_WRITE, 32'h0, 8'd4, 8'd1, 1'b1));
    send_word(make_word(OP_WRITE, 32'h0, 8'd1, 8'd10, 1'b1));
    send_word(make_word(OP_WRITE, 32'h0, 8'd1, 8'd9, 1'b1));
    send_word(make_word(OP_REVERSE, 32'h0000_0000, 8'd0, 8'd0, 1'b0));
    send_word(make_word(OP_LOOKUP, 32'h000F_F000, 8'd0, 8'd0, 1'b0));
    // Index with no register behind it must change nothing
    write_reg(CFG_NONE, 9'h1FF);
    write_reg(CFG_PAGE_COUNT, 9'd0);
    send_word(make_word(OP_WRITE, 32'h0, 8'd0, 8'd0, 1'b0));
    send_word(make_word(OP_LOOKUP, 32'h0000_0000, 8'd0, 8'd0, 1'b0));
    set_regs(5'd0, 9'd511, 9'd511);
    send_word(make_word(OP_REVERSE, 32'd300, 8'd0, 8'd0, 1'b0));
    send_word(make_word(OP_LOOKUP, 32'd7, 8'd0, 8'd0, 1'b0));
    write_reg(CFG_PAGE_SHIFT, 9'h1FF);
    send_word(make_word(OP_LOOKUP, 32'h8000_0001, 8'd0, 8'd0, 1'b0));
    send_word(make_word(OP_REVERSE, 32'h7FFF_FFFF, 8'd0, 8'd0, 1'b0));
  endtask

  task automatic run_phase(logic [SHIFT_W-1:0] shift, logic [CFG_CNT_W-1:0] pages,
                           logic [CFG_CNT_W-1:0] frames, int count);
    set_regs(shift, pages, frames);
    repeat (count) send_word(random_word());
  endtask

  // Random traffic over several register settings under one idle mix
  task automatic test_random_traffic(int send_pct, int recv_pct, int mix);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    case (mix)
      0: begin
        run_phase(5'd12, 9'd256, 9'd256, 40);
        run_phase(5'd0, 9'd1, 9'd1, 20);
        run_phase(5'd5, 9'd64, 9'd40, 40);
      end
      1: begin
        run_phase(5'd20, 9'd256, 9'd256, 45);
        run_phase(5'd8, 9'd16, 9'd300, 30);
        run_phase(5'd31, 9'd511, 9'd511, 25);
      end
      default: begin
        run_phase(5'd3, 9'd200, 9'd128, 45);
        run_phase(5'd16, 9'd0, 9'd8, 10);
        run_phase(5'd10, 9'd256, 9'd256, 45);
      end
    endcase
  endtask

  // Hold the output long enough for the row to fill and stall the input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(5'd12, 9'd256, 9'd256);
    hold_asks <= hold_asks + 1;
    repeat (280) send_word(random_word());
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_word <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    hold_asks <= 0;
    send_idle_pct = 37;
    recv_idle_pct = 88;
    words_sent = 0;
    results_checked = 0;
    reg_writes = 0;
    mismatch_count = 0;
    for (int i = 0; i < PAGES; i++) page_map[i] = '0;
    shadow_shift = RST_PAGE_SHIFT;
    shadow_pages = RST_PAGE_COUNT;
    shadow_frames = RST_FRAME_LIMIT;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    test_reset_state();
    test_write_rules();
    test_config_extremes();
    test_random_traffic(37, 88, 0);
    test_random_traffic(88, 37, 1);
    test_random_traffic(0, 0, 2);
    test_backpressure();

    // Drain, then give the row time to show any stray word
    wait_idle();
    repeat (PAGES + 8) @(negedge clk);

    $display("Ran %0d words (directed edges, random traffic under three idle mixes,",
             words_sent);
    $display("a long output hold), %0d results checked, %0d register writes, %0d mismatches",
             results_checked, reg_writes, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("page_table_address_translator_core regression: pass");
    end else begin
      $display("page_table_address_translator_core regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/ptat_pkg.sv
sv/ptat_decode.sv
sv/ptat_cell.sv
sv/ptat_emit.sv
sv/page_table_address_translator_core.sv
sim/tb_page_table_address_translator_core.sv
